// ===== sv/mid_pkg.sv =====
package mid_pkg;

  localparam logic [2:0] FORM_RM_REG  = 3'd0;
  localparam logic [2:0] FORM_IMM_REG = 3'd1;
  localparam logic [2:0] FORM_IMM_RM  = 3'd2;
  localparam logic [2:0] FORM_MEM_ACC = 3'd3;
  localparam logic [2:0] FORM_ACC_MEM = 3'd4;
  localparam logic [2:0] FORM_UNKNOWN = 3'd5;

  // opcode prefixes of the handled forms
  localparam logic [5:0] OP_RM_REG  = 6'b100010;
  localparam logic [3:0] OP_IMM_REG = 4'b1011;
  localparam logic [6:0] OP_IMM_RM  = 7'b1100011;
  localparam logic [3:0] OP_ACC     = 4'b1010;

  localparam logic [2:0] MAX_LEN = 3'd6;

  // raw instruction as gathered by the front end
  typedef struct packed {
    logic [2:0]  form;
    logic [7:0]  first;
    logic [7:0]  modrm;
    logic [15:0] disp;
    logic [15:0] data;
    logic [2:0]  len;
  } mid_rec_t;

endpackage

// ===== sv/mid_front.sv =====
module mid_front
  import mid_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_code_byte,
  input  logic       q_full,
  output logic       q_push,
  output mid_rec_t   q_rec
);

  logic [2:0]  needed_r, needed_nxt;
  logic [2:0]  taken_r, taken_nxt;
  logic [2:0]  form_r, form_nxt;
  logic [7:0]  first_r, first_nxt;
  logic [7:0]  modrm_r, modrm_nxt;
  logic [15:0] disp_r, disp_nxt;
  logic [15:0] data_r, data_nxt;

  logic        accept;
  logic [2:0]  cls;
  logic        has_modrm;
  logic [2:0]  dstart;
  logic [2:0]  dlen;
  logic [2:0]  off_disp;
  logic [2:0]  off_data;
  logic [15:0] placed;

  function automatic logic [2:0] disp_len(input logic [7:0] m);
    logic [2:0] n;
    n = 3'd0;
    if (m[7:6] == 2'd1) n = 3'd1;
    else if (m[7:6] == 2'd2) n = 3'd2;
    else if (m[7:6] == 2'd0 && m[2:0] == 3'd6) n = 3'd2;
    return n;
  endfunction

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;

  always_comb begin
    cls = FORM_UNKNOWN;
    if (in_code_byte[7:2] == OP_RM_REG) cls = FORM_RM_REG;
    else if (in_code_byte[7:4] == OP_IMM_REG) cls = FORM_IMM_REG;
    else if (in_code_byte[7:1] == OP_IMM_RM) cls = FORM_IMM_RM;
    else if (in_code_byte[7:4] == OP_ACC && in_code_byte[3:2] == 2'd0)
      cls = in_code_byte[1] ? FORM_ACC_MEM : FORM_MEM_ACC;
  end

  assign has_modrm = (form_r == FORM_RM_REG) || (form_r == FORM_IMM_RM);
  assign dstart    = has_modrm ? 3'd2 : 3'd1;
  assign dlen      = has_modrm ? disp_len(modrm_r) :
                     ((form_r == FORM_IMM_REG) ? 3'd0 : 3'd2);
  assign off_disp  = taken_r - dstart;
  assign off_data  = off_disp - dlen;

  always_comb begin
    needed_nxt = needed_r;
    taken_nxt  = taken_r;
    form_nxt   = form_r;
    first_nxt  = first_r;
    modrm_nxt  = modrm_r;
    disp_nxt   = disp_r;
    data_nxt   = data_r;
    q_push     = 1'b0;
    q_rec      = '0;
    placed     = 16'd0;
    if (accept) begin
      if (needed_r == 3'd0) begin
        first_nxt = in_code_byte;
        modrm_nxt = 8'd0;
        disp_nxt  = 16'd0;
        data_nxt  = 16'd0;
        taken_nxt = 3'd1;
        form_nxt  = cls;
        unique case (cls) inside
          FORM_RM_REG, FORM_IMM_RM: begin
            needed_nxt = 3'd2;
          end
          FORM_IMM_REG: begin
            needed_nxt = in_code_byte[3] ? 3'd3 : 3'd2;
          end
          FORM_MEM_ACC, FORM_ACC_MEM: begin
            needed_nxt = 3'd3;
          end
          default: begin
            // unhandled opcode: report at once and restart
            taken_nxt   = 3'd0;
            needed_nxt  = 3'd0;
            q_push      = 1'b1;
            q_rec.form  = FORM_UNKNOWN;
            q_rec.len   = 3'd1;
          end
        endcase
      end else begin
        if (has_modrm && taken_r == 3'd1) begin
          modrm_nxt  = in_code_byte;
          needed_nxt = 3'd2 + disp_len(in_code_byte);
          if (form_r == FORM_IMM_RM)
            needed_nxt = needed_nxt + (first_r[0] ? 3'd2 : 3'd1);
        end else if (taken_r < dstart + dlen) begin
          placed   = off_disp[0] ? {in_code_byte, 8'd0} : {8'd0, in_code_byte};
          disp_nxt = disp_r | placed;
        end else begin
          placed   = off_data[0] ? {in_code_byte, 8'd0} : {8'd0, in_code_byte};
          data_nxt = data_r | placed;
        end
        taken_nxt = taken_r + 3'd1;
        if (taken_nxt >= needed_nxt) begin
          q_push      = 1'b1;
          q_rec.form  = form_r;
          q_rec.first = first_r;
          q_rec.modrm = modrm_nxt;
          q_rec.disp  = disp_nxt;
          q_rec.data  = data_nxt;
          q_rec.len   = needed_nxt;
          needed_nxt  = 3'd0;
          taken_nxt   = 3'd0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      needed_r <= 3'd0;
      taken_r  <= 3'd0;
    end else begin
      needed_r <= needed_nxt;
      taken_r  <= taken_nxt;
    end
  end

  always_ff @(posedge clk) begin
    form_r  <= form_nxt;
    first_r <= first_nxt;
    modrm_r <= modrm_nxt;
    disp_r  <= disp_nxt;
    data_r  <= data_nxt;
  end

  a_needed_range: assert property (@(posedge clk) disable iff (!rst_n)
    needed_r <= MAX_LEN)
    else $error("instruction length out of range");

  a_taken_below: assert property (@(posedge clk) disable iff (!rst_n)
    needed_r != 3'd0 |-> taken_r < needed_r)
    else $error("byte count reached length without completion");

  a_push_len: assert property (@(posedge clk) disable iff (!rst_n)
    q_push |-> (q_rec.len != 3'd0 && q_rec.len <= MAX_LEN))
    else $error("completed instruction with bad length");

endmodule

// ===== sv/mid_queue.sv =====
module mid_queue
  import mid_pkg::*;
#(
  parameter int DEPTH = 4
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     push,
  input  mid_rec_t push_rec,
  input  logic     pop,
  output logic     full,
  output logic     not_empty,
  output mid_rec_t head_rec
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  mid_rec_t         slot_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;

  assign full      = (count_r == FULL_CNT);
  assign not_empty = (count_r != '0);
  assign head_rec  = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) wr_ptr_nxt = (wr_ptr_r == LAST) ? '0 : wr_ptr_r + 1'b1;
    if (pop)  rd_ptr_nxt = (rd_ptr_r == LAST) ? '0 : rd_ptr_r + 1'b1;
    if (push && !pop) count_nxt = count_r + 1'b1;
    else if (pop && !push) count_nxt = count_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) slot_r[wr_ptr_r] <= push_rec;
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !full)
    else $error("queue overflow");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> not_empty)
    else $error("queue underflow");

endmodule

// ===== sv/mid_back.sv =====
module mid_back
  import mid_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               q_not_empty,
  input  mid_rec_t           q_rec,
  output logic               q_pop,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [2:0]         out_form,
  output logic               out_word_flag,
  output logic               out_direction,
  output logic [1:0]         out_mode,
  output logic [2:0]         out_reg_field,
  output logic [2:0]         out_rm_field,
  output logic signed [15:0] out_displacement,
  output logic signed [15:0] out_immediate,
  output logic [2:0]         out_length
);

  logic        valid_r;
  logic [2:0]  form_r, form_nxt;
  logic        w_r, w_nxt;
  logic        d_r, d_nxt;
  logic [1:0]  mode_r, mode_nxt;
  logic [2:0]  reg_r, reg_nxt;
  logic [2:0]  rm_r, rm_nxt;
  logic [15:0] disp_r, disp_nxt;
  logic [15:0] imm_r, imm_nxt;
  logic [2:0]  len_r, len_nxt;
  logic [15:0] imm_ext;

  // advance whenever the output register is free or being drained
  assign q_pop = q_not_empty && (!valid_r || out_ready);

  always_comb begin
    form_nxt = q_rec.form;
    w_nxt    = 1'b0;
    d_nxt    = 1'b0;
    mode_nxt = 2'd0;
    reg_nxt  = 3'd0;
    rm_nxt   = 3'd0;
    disp_nxt = 16'd0;
    imm_nxt  = 16'd0;
    len_nxt  = q_rec.len;
    imm_ext  = q_rec.first[0] ? q_rec.data : {{8{q_rec.data[7]}}, q_rec.data[7:0]};
    unique case (q_rec.form) inside
      FORM_RM_REG, FORM_IMM_RM: begin
        w_nxt    = q_rec.first[0];
        d_nxt    = (q_rec.form == FORM_RM_REG) ? q_rec.first[1] : 1'b0;
        mode_nxt = q_rec.modrm[7:6];
        reg_nxt  = q_rec.modrm[5:3];
        rm_nxt   = q_rec.modrm[2:0];
        disp_nxt = (q_rec.modrm[7:6] == 2'd1) ?
                   {{8{q_rec.disp[7]}}, q_rec.disp[7:0]} : q_rec.disp;
        if (q_rec.form == FORM_IMM_RM) imm_nxt = imm_ext;
      end
      FORM_IMM_REG: begin
        w_nxt   = q_rec.first[3];
        d_nxt   = 1'b1;
        reg_nxt = q_rec.first[2:0];
        imm_nxt = q_rec.first[3] ? q_rec.data :
                  {{8{q_rec.data[7]}}, q_rec.data[7:0]};
      end
      FORM_MEM_ACC, FORM_ACC_MEM: begin
        w_nxt    = q_rec.first[0];
        d_nxt    = (q_rec.form == FORM_MEM_ACC);
        disp_nxt = q_rec.disp;
      end
      default: begin
        form_nxt = FORM_UNKNOWN;
        len_nxt  = 3'd1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (q_pop) begin
      valid_r <= 1'b1;
    end else if (out_ready) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      form_r <= form_nxt;
      w_r    <= w_nxt;
      d_r    <= d_nxt;
      mode_r <= mode_nxt;
      reg_r  <= reg_nxt;
      rm_r   <= rm_nxt;
      disp_r <= disp_nxt;
      imm_r  <= imm_nxt;
      len_r  <= len_nxt;
    end
  end

  assign out_valid        = valid_r;
  assign out_form         = form_r;
  assign out_word_flag    = w_r;
  assign out_direction    = d_r;
  assign out_mode         = mode_r;
  assign out_reg_field    = reg_r;
  assign out_rm_field     = rm_r;
  assign out_displacement = signed'(disp_r);
  assign out_immediate    = signed'(imm_r);
  assign out_length       = len_r;

  a_unknown_len: assert property (@(posedge clk) disable iff (!rst_n)
    (valid_r && form_r == FORM_UNKNOWN) |-> len_r == 3'd1)
    else $error("unhandled opcode with length other than one");

endmodule

// ===== sv/mov_instruction_decoder_top.sv =====
// Byte-serial MOV decoder: one code byte accepted per cycle while the record queue is not full.
// The record is written into the queue at the edge that accepts the instruction's last byte,
// then into the output register behind out_valid once that register is free or being drained.
// Throughput is set by the front end's single byte-capture stage; the record
// queue (DEPTH entries) absorbs output stalls before in_ready drops.
// Synchronous active-low reset empties the queue and restarts at a first byte.
module mov_instruction_decoder_top
  import mid_pkg::*;
#(
  parameter int DEPTH = 4
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [7:0]         in_code_byte,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [2:0]         out_form,
  output logic               out_word_flag,
  output logic               out_direction,
  output logic [1:0]         out_mode,
  output logic [2:0]         out_reg_field,
  output logic [2:0]         out_rm_field,
  output logic signed [15:0] out_displacement,
  output logic signed [15:0] out_immediate,
  output logic [2:0]         out_length
);

  logic     q_full;
  logic     q_push;
  logic     q_pop;
  logic     q_not_empty;
  mid_rec_t push_rec;
  mid_rec_t head_rec;

  mid_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_code_byte (in_code_byte),
    .q_full       (q_full),
    .q_push       (q_push),
    .q_rec        (push_rec)
  );

  mid_queue #(
    .DEPTH (DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_rec  (push_rec),
    .pop       (q_pop),
    .full      (q_full),
    .not_empty (q_not_empty),
    .head_rec  (head_rec)
  );

  mid_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .q_not_empty      (q_not_empty),
    .q_rec            (head_rec),
    .q_pop            (q_pop),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_form         (out_form),
    .out_word_flag    (out_word_flag),
    .out_direction    (out_direction),
    .out_mode         (out_mode),
    .out_reg_field    (out_reg_field),
    .out_rm_field     (out_rm_field),
    .out_displacement (out_displacement),
    .out_immediate    (out_immediate),
    .out_length       (out_length)
  );

endmodule
